// ===== hdl/nbm_pkg.sv =====
// shared types and constants for the nibble bank mapper
`timescale 1ns / 1ps
package nbm_pkg;

	localparam int BANK_W          = 8;
	localparam int BANK_REGS       = 11;
	localparam int BANK_IDX_W      = 4;
	localparam int PRG_WINDOWS     = 3;
	localparam int ADDR_W          = 16;
	localparam int DATA_W          = 8;
	localparam int NIB_W           = 4;
	localparam int CNT_W           = 16;
	localparam int SLOT_W          = 3;
	localparam int CFG_DATA_W      = 9;
	localparam int CFG_IDX_W       = 1;

	localparam logic [CNT_W-1:0]      CYCLES_PER_LINE  = 16'd113;
	localparam logic [CNT_W-1:0]      QUIRK_RELOAD     = 16'd114;
	localparam logic [CFG_DATA_W-1:0] PRG_BANK_COUNT_RST = 9'd32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_QUIRK   = 1'd1;

	// address page codes (top nibble of the bus address)
	localparam logic [3:0] PAGE_PRG_LO  = 4'h8;
	localparam logic [3:0] PAGE_PRG_HI  = 4'h9;
	localparam logic [3:0] PAGE_CHR_LO  = 4'hA;
	localparam logic [3:0] PAGE_CHR_HI  = 4'hD;
	localparam logic [3:0] PAGE_IRQ_LAT = 4'hE;
	localparam logic [3:0] PAGE_CTRL    = 4'hF;

	// offsets inside the control page
	localparam logic [11:0] CTRL_RELOAD = 12'h000;
	localparam logic [11:0] CTRL_ENABLE = 12'h001;
	localparam logic [11:0] CTRL_MIRROR = 12'h002;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_PRG    = 2'd1,
		KIND_CHR    = 2'd2,
		KIND_MIRROR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MIR_HORIZONTAL = 2'd0,
		MIR_VERTICAL   = 2'd1,
		MIR_SINGLE     = 2'd2
	} mirror_t;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_TICK  = 1'b1
	} mode_t;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] bus_address;
		logic [DATA_W-1:0] bus_data;
	} item_t;

	typedef struct packed {
		logic              irq_pulse;
		kind_t             update_kind;
		logic [SLOT_W-1:0] update_slot;
		logic [BANK_W-1:0] bank_number;
		mirror_t           mirror_mode;
	} result_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== hdl/nbm_if.sv =====
// handshake channels for bus/tick items and result items
`timescale 1ns / 1ps
interface nbm_in_if;
	import nbm_pkg::*;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [ADDR_W-1:0] bus_address;
	logic [DATA_W-1:0] bus_data;

	modport source (output valid, mode, bus_address, bus_data, input ready);
	modport sink   (input valid, mode, bus_address, bus_data, output ready);
endinterface

interface nbm_out_if;
	import nbm_pkg::*;
	logic              valid;
	logic              ready;
	logic              irq_pulse;
	logic [1:0]        update_kind;
	logic [SLOT_W-1:0] update_slot;
	logic [BANK_W-1:0] bank_number;
	logic [1:0]        mirror_mode;

	modport source (output valid, irq_pulse, update_kind, update_slot, bank_number,
		mirror_mode, input ready);
	modport sink   (input valid, irq_pulse, update_kind, update_slot, bank_number,
		mirror_mode, output ready);
endinterface

// ===== hdl/nbm_core.sv =====
// mapper state: bank registers, irq latch/counter/enable and the per-item update
`timescale 1ns / 1ps
module nbm_core (
	input  logic            clk,
	input  logic            arst_n,
	input  nbm_pkg::cfg_wr_t cfg,
	input  logic            fire,
	input  nbm_pkg::item_t  item,
	output nbm_pkg::result_t result
);
	import nbm_pkg::*;

	logic [BANK_W-1:0]     bank_q [BANK_REGS];
	logic [CNT_W-1:0]      latch_q;
	logic [CNT_W-1:0]      counter_q;
	logic                  irq_en_q;
	logic                  quirk_q;

	logic [3:0]            page;
	logic [11:0]           offs;
	logic [NIB_W-1:0]      nib;
	logic                  bank_hit;
	logic [BANK_IDX_W-1:0] bank_idx;
	logic [BANK_IDX_W-1:0] chr_base;
	logic [BANK_W-1:0]     bank_new;
	logic                  latch_hit;
	logic                  reload_hit;
	logic                  enable_hit;
	logic                  mirror_hit;
	logic                  tick_fire;
	logic                  tick_sub;
	logic [CNT_W-1:0]      latch_new;
	logic [BANK_W-1:0]     third_rst;

	assign page = item.bus_address[15:12];
	assign offs = item.bus_address[11:0];
	assign nib  = item.bus_data[NIB_W-1:0];
	assign third_rst = PRG_BANK_COUNT_RST[BANK_W-1:0] - BANK_W'(2);

	// address decode
	always_comb begin
		bank_hit   = 1'b0;
		latch_hit  = 1'b0;
		reload_hit = 1'b0;
		enable_hit = 1'b0;
		mirror_hit = 1'b0;
		if (item.mode == MODE_WRITE) begin
			if (page >= PAGE_PRG_LO && page <= PAGE_CHR_HI && offs <= 12'd3 &&
				!(page == PAGE_PRG_HI && offs >= 12'd2)) begin
				bank_hit = 1'b1;
			end
			latch_hit  = (page == PAGE_IRQ_LAT) && (offs <= 12'd3);
			reload_hit = (page == PAGE_CTRL) && (offs == CTRL_RELOAD);
			enable_hit = (page == PAGE_CTRL) && (offs == CTRL_ENABLE);
			mirror_hit = (page == PAGE_CTRL) && (offs == CTRL_MIRROR);
		end
	end

	// bank register index and merged nibble
	assign chr_base = BANK_IDX_W'(page - PAGE_CHR_LO);
	always_comb begin
		priority if (page == PAGE_PRG_LO) begin
			bank_idx = {{(BANK_IDX_W-1){1'b0}}, offs[1]};
		end else if (page == PAGE_PRG_HI) begin
			bank_idx = BANK_IDX_W'(2);
		end else begin
			bank_idx = BANK_IDX_W'(PRG_WINDOWS) + {chr_base[BANK_IDX_W-2:0], offs[1]};
		end
	end

	always_comb begin
		if (offs[0]) begin
			bank_new = {nib, bank_q[bank_idx][NIB_W-1:0]};
		end else begin
			bank_new = {bank_q[bank_idx][BANK_W-1:NIB_W], nib};
		end
	end

	// reload latch nibble merge
	always_comb begin
		latch_new = latch_q;
		latch_new[offs[1:0]*NIB_W +: NIB_W] = nib;
	end

	// line tick decision
	assign tick_fire = (item.mode == MODE_TICK) && irq_en_q && (counter_q <= CYCLES_PER_LINE);
	assign tick_sub  = (item.mode == MODE_TICK) && irq_en_q && (counter_q > CYCLES_PER_LINE);

	// result fields
	always_comb begin
		result = '0;
		result.irq_pulse = tick_fire;
		if (bank_hit) begin
			result.bank_number = bank_new;
			if (bank_idx < BANK_IDX_W'(PRG_WINDOWS)) begin
				result.update_kind = KIND_PRG;
				result.update_slot = SLOT_W'(bank_idx);
			end else begin
				result.update_kind = KIND_CHR;
				result.update_slot = SLOT_W'(bank_idx - BANK_IDX_W'(PRG_WINDOWS));
			end
		end else if (mirror_hit) begin
			result.update_kind = KIND_MIRROR;
			unique case (item.bus_data[1:0])
				2'd0:    result.mirror_mode = MIR_HORIZONTAL;
				2'd1:    result.mirror_mode = MIR_VERTICAL;
				default: result.mirror_mode = MIR_SINGLE;
			endcase
		end
	end

	// bank registers, third program window also follows the bank count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANK_REGS; i++) begin
				bank_q[i] <= '0;
			end
			bank_q[1] <= BANK_W'(1);
			bank_q[2] <= third_rst;
		end else if (cfg.we && cfg.index == CFG_PRG_BANK_COUNT) begin
			bank_q[2] <= cfg.data[BANK_W-1:0] - BANK_W'(2);
		end else if (fire && bank_hit) begin
			bank_q[bank_idx] <= bank_new;
		end
	end

	// quirk configuration bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quirk_q <= 1'b0;
		end else if (cfg.we && cfg.index == CFG_RELOAD_QUIRK) begin
			quirk_q <= cfg.data[0];
		end
	end

	// irq latch, counter and enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q   <= '0;
			counter_q <= '0;
			irq_en_q  <= 1'b0;
		end else if (fire) begin
			if (latch_hit) begin
				latch_q <= latch_new;
			end
			if (reload_hit) begin
				counter_q <= latch_q;
			end
			if (enable_hit) begin
				irq_en_q <= item.bus_data[0];
			end
			if (tick_fire) begin
				counter_q <= quirk_q ? QUIRK_RELOAD : '0;
				irq_en_q  <= 1'b0;
			end else if (tick_sub) begin
				counter_q <= counter_q - CYCLES_PER_LINE;
			end
		end
	end

endmodule

// ===== hdl/nibble_bank_mapper_with_line_irq_top.sv =====
// Bank mapper with line irq: an accepted transaction is held in the input register, its result is
// computed combinationally from it and captured in the result register, from which it is offered;
// one transaction per cycle is sustained while the receiver keeps taking results. Reset is
// asynchronous, active low: bank registers go to 0, 1, 30 and zero, bank count to 32, irq latch,
// counter and enable to zero, quirk off; both pipeline registers empty.
`timescale 1ns / 1ps
module nibble_bank_mapper_with_line_irq_top (
	input  logic                           clk,
	input  logic                           arst_n,
	nbm_in_if.sink                         in_ch,
	nbm_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [nbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nbm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nbm_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t result;
	logic    advance;
	cfg_wr_t cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// stage 1 moves into the result register when it is empty or being drained
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.mode        <= in_ch.mode;
			item_s1.bus_address <= in_ch.bus_address;
			item_s1.bus_data    <= in_ch.bus_data;
		end
	end

	nbm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (advance),
		.item   (item_s1),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.irq_pulse   = res_q.irq_pulse;
	assign out_ch.update_kind = res_q.update_kind;
	assign out_ch.update_slot = res_q.update_slot;
	assign out_ch.bank_number = res_q.bank_number;
	assign out_ch.mirror_mode = res_q.mirror_mode;

endmodule

// ===== sim/tb_nibble_bank_mapper_with_line_irq_top.sv =====
// self-checking testbench for the nibble bank mapper with line irq
`timescale 1ns / 1ps
module tb_nibble_bank_mapper_with_line_irq_top;
	import nbm_pkg::*;

	localparam int CLK_HALF        = 6;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int LONG_HOLD       = 200;
	localparam int RANDOM_PHASES   = 5;
	localparam int ITEMS_PER_PHASE = 130;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	nbm_in_if  in_ch ();
	nbm_out_if out_ch ();

	nibble_bank_mapper_with_line_irq_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// mapper state as the testbench tracks it
	logic [BANK_W-1:0]     bank_regs [BANK_REGS];
	logic [CNT_W-1:0]      reload_shadow;
	logic [CNT_W-1:0]      line_count;
	logic                  irq_on;
	logic                  quirk_on;

	result_t pending_results [$];
	int      err_cnt   = 0;
	int      item_cnt  = 0;
	int      cycles    = 0;
	bit      calm      = 1'b0;
	bit      hold_request = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_nibble_bank_mapper_with_line_irq_top: errors");
			$finish;
		end
	end

	// gap length for either side: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// apply one bus write or line tick to the tracked state, return the expected result
	function automatic result_t apply_bus_item(input item_t it);
		result_t    r;
		logic [3:0] page;
		logic [11:0] ofs;
		logic [3:0] nib;
		int         idx;
		r     = '0;
		page  = it.bus_address[15:12];
		ofs   = it.bus_address[11:0];
		nib   = it.bus_data[3:0];
		if (it.mode == MODE_TICK) begin
			if (irq_on) begin
				if (line_count <= CYCLES_PER_LINE) begin
					r.irq_pulse = 1'b1;
					line_count  = quirk_on ? QUIRK_RELOAD : '0;
					irq_on      = 1'b0;
				end else begin
					line_count = line_count - CYCLES_PER_LINE;
				end
			end
		end else if (page >= PAGE_PRG_LO && page <= PAGE_CHR_HI && ofs <= 12'd3 &&
				!(page == PAGE_PRG_HI && ofs >= 12'd2)) begin
			// bank nibble write
			if (page == PAGE_PRG_LO)
				idx = ofs[1];
			else if (page == PAGE_PRG_HI)
				idx = PRG_WINDOWS - 1;
			else
				idx = PRG_WINDOWS + (page - PAGE_CHR_LO) * 2 + ofs[1];
			if (ofs[0])
				bank_regs[idx][7:4] = nib;
			else
				bank_regs[idx][3:0] = nib;
			r.bank_number = bank_regs[idx];
			if (idx < PRG_WINDOWS) begin
				r.update_kind = KIND_PRG;
				r.update_slot = SLOT_W'(idx);
			end else begin
				r.update_kind = KIND_CHR;
				r.update_slot = SLOT_W'(idx - PRG_WINDOWS);
			end
		end else if (page == PAGE_IRQ_LAT && ofs <= 12'd3) begin
			reload_shadow[ofs[1:0] * NIB_W +: NIB_W] = nib;
		end else if (page == PAGE_CTRL && ofs == CTRL_RELOAD) begin
			line_count = reload_shadow;
		end else if (page == PAGE_CTRL && ofs == CTRL_ENABLE) begin
			irq_on = it.bus_data[0];
		end else if (page == PAGE_CTRL && ofs == CTRL_MIRROR) begin
			r.update_kind = KIND_MIRROR;
			r.mirror_mode = it.bus_data[1] ? MIR_SINGLE : mirror_t'(it.bus_data[1:0]);
		end
		return r;
	endfunction

	// offer one transaction, wait for acceptance, queue its expected result
	task automatic send_item(input mode_t m, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		item_t it;
		int    gap;
		it.mode        = m;
		it.bus_address = a;
		it.bus_data    = d;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.mode        <= it.mode;
		in_ch.bus_address <= it.bus_address;
		in_ch.bus_data    <= it.bus_data;
		do @(posedge clk); while (!in_ch.ready);
		pending_results.push_back(apply_bus_item(it));
		item_cnt++;
	endtask

	// random nibble write to any bank window
	task automatic send_bank_write();
		int          idx;
		logic [3:0]  page;
		logic [11:0] ofs;
		idx = $urandom_range(0, BANK_REGS - 1);
		if (idx < PRG_WINDOWS - 1) begin
			page = PAGE_PRG_LO;
			ofs  = 12'(idx * 2);
		end else if (idx == PRG_WINDOWS - 1) begin
			page = PAGE_PRG_HI;
			ofs  = '0;
		end else begin
			page = 4'(PAGE_CHR_LO + (idx - PRG_WINDOWS) / 2);
			ofs  = 12'(((idx - PRG_WINDOWS) % 2) * 2);
		end
		ofs[0] = $urandom_range(0, 1);
		send_item(MODE_WRITE, {page, ofs}, 8'($urandom));
	endtask

	// stop offering and wait until every expected result is in
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write on an idle block
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PRG_BANK_COUNT) begin
			bank_regs[PRG_WINDOWS - 1] = BANK_W'(val - 9'd2);
		end else begin
			quirk_on = val[0];
		end
	endtask

	// unmapped addresses, page holes, bank nibbles at extremes, every mirroring value
	task automatic test_directed_map();
		send_item(MODE_TICK, 16'hFFFF, 8'hFF);
		send_item(MODE_WRITE, 16'h0000, 8'hFF);
		send_item(MODE_WRITE, {PAGE_PRG_HI, 12'h002}, 8'h0F);
		send_item(MODE_WRITE, 16'hFFFF, 8'h00);
		send_item(MODE_WRITE, {PAGE_PRG_LO, 12'h000}, 8'hFF);
		send_item(MODE_WRITE, {PAGE_PRG_LO, 12'h003}, 8'hF0);
		send_item(MODE_WRITE, {PAGE_PRG_HI, 12'h001}, 8'h00);
		send_item(MODE_WRITE, {PAGE_CHR_LO, 12'h000}, 8'hFF);
		send_item(MODE_WRITE, {PAGE_CHR_HI, 12'h003}, 8'hAA);
		send_item(MODE_WRITE, {4'(PAGE_CHR_LO + 4'd2), 12'h002}, 8'h55);
		for (int m = 0; m < 3; m++)
			send_item(MODE_WRITE, {PAGE_CTRL, CTRL_MIRROR}, 8'(m));
		send_item(MODE_WRITE, {PAGE_CTRL, CTRL_MIRROR}, 8'hFF);
	endtask

	// counter of 226 takes one subtract then fires right at the line length
	task automatic test_irq_boundary();
		send_item(MODE_WRITE, {PAGE_IRQ_LAT, 12'h000}, 8'hF2);
		send_item(MODE_WRITE, {PAGE_IRQ_LAT, 12'h001}, 8'h0E);
		send_item(MODE_WRITE, {PAGE_IRQ_LAT, 12'h002}, 8'hF0);
		send_item(MODE_WRITE, {PAGE_IRQ_LAT, 12'h003}, 8'h00);
		send_item(MODE_WRITE, {PAGE_CTRL, CTRL_RELOAD}, 8'h00);
		send_item(MODE_WRITE, {PAGE_CTRL, CTRL_ENABLE}, 8'hFE);
		send_item(MODE_TICK, 16'h0000, 8'h00);
		send_item(MODE_WRITE, {PAGE_CTRL, CTRL_ENABLE}, 8'h01);
		repeat (3) send_item(MODE_TICK, 16'h0000, 8'h00);
	endtask

	// quirk reload of 114 takes one subtract before the next fire
	task automatic test_reload_quirk();
		write_reg(CFG_RELOAD_QUIRK, 9'h1FF);
		send_item(MODE_WRITE, {PAGE_CTRL, CTRL_ENABLE}, 8'h01);
		send_item(MODE_TICK, 16'hFFFF, 8'hFF);
		send_item(MODE_WRITE, {PAGE_CTRL, CTRL_ENABLE}, 8'hFF);
		repeat (2) send_item(MODE_TICK, 16'h0000, 8'h00);
		write_reg(CFG_RELOAD_QUIRK, 9'h000);
		send_item(MODE_WRITE, {PAGE_CTRL, CTRL_ENABLE}, 8'h01);
		repeat (2) send_item(MODE_TICK, 16'h0000, 8'h00);
	endtask

	// bank count extremes, including counts below two that wrap the reset bank
	task automatic test_bank_count_extremes();
		logic [CFG_DATA_W-1:0] counts [6];
		counts = '{9'd256, 9'd2, 9'd1, 9'd0, 9'd255, PRG_BANK_COUNT_RST};
		foreach (counts[i]) begin
			write_reg(CFG_PRG_BANK_COUNT, counts[i]);
			send_item(MODE_WRITE, {PAGE_PRG_HI, 12'h000}, 8'($urandom));
			send_item(MODE_WRITE, {PAGE_PRG_HI, 12'h001}, 8'($urandom));
		end
	endtask

	// long receiver hold while the sender keeps offering back to back
	task automatic test_backpressure();
		calm         = 1'b1;
		hold_request = 1'b1;
		repeat (40) send_bank_write();
		calm = 1'b0;
	endtask

	// random phases: irq sequences, bank and mirroring writes, noise
	task automatic test_random_traffic();
		int              goal;
		int              pick;
		int              n;
		logic [CNT_W-1:0] lat;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_reg(CFG_PRG_BANK_COUNT, CFG_DATA_W'($urandom_range(2, 256)));
			write_reg(CFG_RELOAD_QUIRK, CFG_DATA_W'($urandom));
			calm = (ph == 2);
			goal = item_cnt + ITEMS_PER_PHASE;
			while (item_cnt < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 30) begin
					// irq setup, sometimes broken, then ticks mixed with bank writes
					lat = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom) :
						CNT_W'($urandom_range(0, 1500));
					for (int k = 0; k < CNT_W / NIB_W; k++)
						send_item(MODE_WRITE, {PAGE_IRQ_LAT, 12'(k)},
							{4'($urandom), lat[k * NIB_W +: NIB_W]});
					if ($urandom_range(0, 6) != 0)
						send_item(MODE_WRITE, {PAGE_CTRL, CTRL_RELOAD}, 8'($urandom));
					send_item(MODE_WRITE, {PAGE_CTRL, CTRL_ENABLE},
						{7'($urandom), ($urandom_range(0, 6) != 0)});
					n = $urandom_range(1, 16);
					repeat (n) begin
						if ($urandom_range(0, 3) == 0)
							send_bank_write();
						send_item(MODE_TICK, 16'($urandom), 8'($urandom));
					end
				end else if (pick < 65) begin
					send_bank_write();
				end else if (pick < 75) begin
					send_item(MODE_WRITE, {PAGE_CTRL, CTRL_MIRROR}, 8'($urandom));
				end else if (pick < 85) begin
					send_item(MODE_TICK, 16'($urandom), 8'($urandom));
				end else begin
					case ($urandom_range(0, 3))
						0: send_item(MODE_WRITE, 16'($urandom), 8'($urandom));
						1: send_item(MODE_WRITE,
							{PAGE_PRG_HI, 12'($urandom_range(2, 4095))}, 8'($urandom));
						2: send_item(MODE_WRITE,
							{4'($urandom_range(PAGE_PRG_LO, PAGE_IRQ_LAT)),
							12'($urandom_range(4, 4095))}, 8'($urandom));
						default: send_item(MODE_WRITE,
							{PAGE_CTRL, 12'($urandom_range(3, 4095))}, 8'($urandom));
					endcase
				end
			end
		end
		calm = 1'b0;
	endtask

	// receiver: random stalls, plus a long hold on request
	initial begin
		int hold_left;
		hold_left    = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end else if (hold_left == 0) begin
				hold_left = pick_gap();
			end
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no expectation waiting");
				err_cnt++;
			end else begin
				exp_r = pending_results.pop_front();
				if (out_ch.irq_pulse !== exp_r.irq_pulse) begin
					$error("irq_pulse: expected %0d, got %0d", exp_r.irq_pulse,
						out_ch.irq_pulse);
					err_cnt++;
				end
				if (out_ch.update_kind !== exp_r.update_kind) begin
					$error("update_kind: expected %0d, got %0d", exp_r.update_kind,
						out_ch.update_kind);
					err_cnt++;
				end
				if (out_ch.update_slot !== exp_r.update_slot) begin
					$error("update_slot: expected %0d, got %0d", exp_r.update_slot,
						out_ch.update_slot);
					err_cnt++;
				end
				if (out_ch.bank_number !== exp_r.bank_number) begin
					$error("bank_number: expected %0d, got %0d", exp_r.bank_number,
						out_ch.bank_number);
					err_cnt++;
				end
				if (out_ch.mirror_mode !== exp_r.mirror_mode) begin
					$error("mirror_mode: expected %0d, got %0d", exp_r.mirror_mode,
						out_ch.mirror_mode);
					err_cnt++;
				end
			end
		end
	end

	// main sequence
	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_PRG_BANK_COUNT;
		cfg_data          = '0;
		in_ch.valid       = 1'b0;
		in_ch.mode        = MODE_WRITE;
		in_ch.bus_address = '0;
		in_ch.bus_data    = '0;
		quirk_on          = 1'b0;
		reload_shadow     = '0;
		line_count        = '0;
		irq_on            = 1'b0;
		foreach (bank_regs[i])
			bank_regs[i] = '0;
		bank_regs[1]               = 8'd1;
		bank_regs[PRG_WINDOWS - 1] = BANK_W'(PRG_BANK_COUNT_RST - 9'd2);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_map();
		test_irq_boundary();
		test_reload_quirk();
		test_bank_count_extremes();
		test_backpressure();
		test_random_traffic();
		drain();

		if (err_cnt == 0)
			$display("tb_nibble_bank_mapper_with_line_irq_top: clean");
		else
			$display("tb_nibble_bank_mapper_with_line_irq_top: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/nbm_pkg.sv
hdl/nbm_if.sv
hdl/nbm_core.sv
hdl/nibble_bank_mapper_with_line_irq_top.sv
sim/tb_nibble_bank_mapper_with_line_irq_top.sv
